// ===== hdl/ertp_pkg.sv =====
// Package for the Euler rotate/translate/project vertex block.
// Word types, configuration record, op codes and register indexes.
// No dependencies.
`timescale 1ns / 1ps

package ertp_pkg;

    typedef struct packed {
        logic signed [31:0] x_in;
        logic signed [31:0] y_in;
        logic signed [31:0] z_in;
        logic               is_normal;
        logic               last_vertex;
    } t_vtx_in;

    typedef struct packed {
        logic signed [31:0] x_out;
        logic signed [31:0] y_out;
        logic signed [31:0] z_out;
        logic               divide_fault;
        logic               last_out;
    } t_vtx_out;

    typedef enum logic [1:0] {
        OP_NORMAL  = 2'd0,
        OP_PLACE   = 2'd1,
        OP_PROJECT = 2'd2
    } t_op;

    typedef struct packed {
        t_vtx_in vtx;
        t_op     op;
    } t_item;

    typedef struct packed {
        logic        [31:0] sc_x;
        logic        [31:0] sc_y;
        logic        [31:0] sc_z;
        logic signed [31:0] off_x;
        logic signed [31:0] off_y;
        logic signed [31:0] off_z;
        logic               project;
    } t_cfg;

    localparam int          ADDR_W   = 5;
    localparam logic [2:0]  REG_SC_X = 3'd0;
    localparam logic [2:0]  REG_SC_Y = 3'd1;
    localparam logic [2:0]  REG_SC_Z = 3'd2;
    localparam logic [2:0]  REG_OFF_X = 3'd3;
    localparam logic [2:0]  REG_OFF_Y = 3'd4;
    localparam logic [2:0]  REG_OFF_Z = 3'd5;
    localparam logic [2:0]  REG_PROJ = 3'd6;
    localparam logic [31:0] SC_RESET = 32'h4000_0000;

endpackage

// ===== hdl/ertp_fifo.sv =====
// Two-entry register queue, used between front and back and at the output.
// No dependencies.
`timescale 1ns / 1ps

module ertp_fifo #(
    parameter int WIDTH = 8
) (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_push,
    input  logic             i_pop,
    input  logic [WIDTH-1:0] i_data,
    output logic             o_full,
    output logic             o_empty,
    output logic [WIDTH-1:0] o_data
);

    logic [WIDTH-1:0] r_mem [0:1];
    logic             r_wp, r_rp;
    logic [1:0]       r_cnt;
    logic             do_push, do_pop;

    assign o_full  = (r_cnt == 2'd2);
    assign o_empty = (r_cnt == 2'd0);
    assign o_data  = r_mem[r_rp];
    assign do_push = i_push && !o_full;
    assign do_pop  = i_pop && !o_empty;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (do_push) r_wp <= ~r_wp;
            if (do_pop) r_rp <= ~r_rp;
            r_cnt <= r_cnt + {1'b0, do_push} - {1'b0, do_pop};
        end
    end

    always_ff @(posedge i_clk) begin
        if (do_push) r_mem[r_wp] <= i_data;
    end

endmodule

// ===== hdl/ertp_front.sv =====
// Front end: takes vertex words, tags each with its operation, queues them.
// Depends on ertp_pkg and ertp_fifo.
`timescale 1ns / 1ps

module ertp_front (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_project,
    input  logic            i_push,
    output logic            o_full,
    input  ertp_pkg::t_vtx_in i_vtx,
    input  logic            i_pop,
    output logic            o_empty,
    output ertp_pkg::t_item o_item
);

    ertp_pkg::t_item item;

    always_comb begin
        item.vtx = i_vtx;
        if (i_vtx.is_normal) item.op = ertp_pkg::OP_NORMAL;
        else if (i_project)  item.op = ertp_pkg::OP_PROJECT;
        else                 item.op = ertp_pkg::OP_PLACE;
    end

    ertp_fifo #(.WIDTH($bits(ertp_pkg::t_item))) u_q (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (i_push),
        .i_pop  (i_pop),
        .i_data (item),
        .o_full (o_full),
        .o_empty(o_empty),
        .o_data (o_item)
    );

endmodule

// ===== hdl/ertp_rot.sv =====
// One plane rotation: p = a*c + b*s, q = b*c - a*s, Q1.14 rounding, saturated.
// Two stages. No dependencies.
`timescale 1ns / 1ps

module ertp_rot #(
    parameter int W = 32
) (
    input  logic                i_clk,
    input  logic                i_en,
    input  logic signed [W-1:0] i_a,
    input  logic signed [W-1:0] i_b,
    input  logic        [31:0]  i_cs,
    output logic signed [W-1:0] o_p,
    output logic signed [W-1:0] o_q
);

    localparam logic signed [W+17:0] HI = signed'({{19{1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [W+17:0] LO = signed'({{19{1'b1}}, {(W-1){1'b0}}});
    localparam logic signed [W+17:0] RND = (W+18)'(8192);

    logic signed [15:0]   c, s;
    logic signed [W+15:0] r_ac, r_bs, r_bc, r_as;
    logic signed [W+17:0] sp, sq, hp, hq;

    assign c = signed'(i_cs[31:16]);
    assign s = signed'(i_cs[15:0]);

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_ac <= i_a * c;
            r_bs <= i_b * s;
            r_bc <= i_b * c;
            r_as <= i_a * s;
        end
    end

    always_comb begin
        sp = (W+18)'(r_ac) + (W+18)'(r_bs) + RND;
        sq = (W+18)'(r_bc) - (W+18)'(r_as) + RND;
        hp = sp >>> 14;
        hq = sq >>> 14;
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            o_p <= (hp > HI) ? HI[W-1:0] : (hp < LO) ? LO[W-1:0] : hp[W-1:0];
            o_q <= (hq > HI) ? HI[W-1:0] : (hq < LO) ? LO[W-1:0] : hq[W-1:0];
        end
    end

endmodule

// ===== hdl/ertp_back.sv =====
// Back end: x, y, z rotations, translation, perspective divide (bit per stage).
// Depends on ertp_pkg and ertp_rot. Whole pipe advances while output has room.
`timescale 1ns / 1ps

module ertp_back #(
    parameter int W = 32
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  ertp_pkg::t_cfg     i_cfg,
    input  logic               i_empty,
    output logic               o_pop,
    input  ertp_pkg::t_item    i_item,
    input  logic               i_full,
    output logic               o_push,
    output ertp_pkg::t_vtx_out o_res
);

    localparam int SW = ((W > 32) ? W : 32) + 2;
    localparam int NQ = W + 16;
    localparam logic signed [SW-1:0] HI_S = signed'({{(SW-W+1){1'b0}}, {(W-1){1'b1}}});
    localparam logic signed [SW-1:0] LO_S = signed'({{(SW-W+1){1'b1}}, {(W-1){1'b0}}});
    localparam logic signed [SW-1:0] ONE_Q16 = SW'(65536);
    localparam logic [NQ-1:0] QMAX  = {{(NQ-W+1){1'b0}}, {(W-1){1'b1}}};
    localparam logic [NQ-1:0] QMAX1 = QMAX + NQ'(1);
    localparam logic signed [W-1:0] CMAX = {1'b0, {(W-1){1'b1}}};
    localparam logic signed [W-1:0] CMIN = {1'b1, {(W-1){1'b0}}};

    function automatic logic signed [W-1:0] clampw(input logic signed [SW-1:0] v);
        if (v > HI_S) return HI_S[W-1:0];
        if (v < LO_S) return LO_S[W-1:0];
        return v[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] qsat(input logic [NQ-1:0] q, input logic neg);
        logic [NQ-1:0] nq;
        nq = -q;
        if (!neg) return (q > QMAX) ? CMAX : q[W-1:0];
        return (q > QMAX1) ? CMIN : nq[W-1:0];
    endfunction

    function automatic logic signed [W-1:0] fsat(input logic signed [W-1:0] v);
        if (v > 0) return CMAX;
        if (v < 0) return CMIN;
        return '0;
    endfunction

    logic en;
    assign en    = !i_full;
    assign o_pop = en && !i_empty;

    // input stage
    logic                r_v0, r_l0;
    ertp_pkg::t_op       r_op0;
    logic signed [W-1:0] r_x0, r_y0, r_z0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_v0 <= 1'b0;
        else if (en)  r_v0 <= o_pop;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_x0  <= W'(i_item.vtx.x_in);
            r_y0  <= W'(i_item.vtx.y_in);
            r_z0  <= W'(i_item.vtx.z_in);
            r_op0 <= i_item.op;
            r_l0  <= i_item.vtx.last_vertex;
        end
    end

    // rotations about x, then y, then z
    logic                r_cv [0:5];
    ertp_pkg::t_op       r_cop [0:5];
    logic                r_cl [0:5];
    logic signed [W-1:0] r_xd [0:1];
    logic signed [W-1:0] r_yd [0:1];
    logic signed [W-1:0] r_zd [0:1];
    logic signed [W-1:0] y1, z1, x2, z2, x3, y3;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k < 6; k++) r_cv[k] <= 1'b0;
        end else if (en) begin
            r_cv[0] <= r_v0;
            for (int k = 1; k < 6; k++) r_cv[k] <= r_cv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_cop[0] <= r_op0;
            r_cl[0]  <= r_l0;
            for (int k = 1; k < 6; k++) begin
                r_cop[k] <= r_cop[k-1];
                r_cl[k]  <= r_cl[k-1];
            end
            r_xd[0] <= r_x0;
            r_xd[1] <= r_xd[0];
            r_yd[0] <= y1;
            r_yd[1] <= r_yd[0];
            r_zd[0] <= z2;
            r_zd[1] <= r_zd[0];
        end
    end

    ertp_rot #(.W(W)) u_rx (
        .i_clk(i_clk), .i_en(en), .i_a(r_y0), .i_b(r_z0), .i_cs(i_cfg.sc_x),
        .o_p(y1), .o_q(z1)
    );
    ertp_rot #(.W(W)) u_ry (
        .i_clk(i_clk), .i_en(en), .i_a(z1), .i_b(r_xd[1]), .i_cs(i_cfg.sc_y),
        .o_p(z2), .o_q(x2)
    );
    ertp_rot #(.W(W)) u_rz (
        .i_clk(i_clk), .i_en(en), .i_a(x2), .i_b(r_yd[1]), .i_cs(i_cfg.sc_z),
        .o_p(x3), .o_q(y3)
    );

    // translate
    logic                r_vt, r_lt;
    ertp_pkg::t_op       r_opt;
    logic signed [W-1:0] r_xt, r_yt, r_zt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vt <= 1'b0;
        else if (en)  r_vt <= r_cv[5];
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_opt <= r_cop[5];
            r_lt  <= r_cl[5];
            if (r_cop[5] == ertp_pkg::OP_NORMAL) begin
                r_xt <= x3;
                r_yt <= y3;
                r_zt <= r_zd[1];
            end else begin
                r_xt <= clampw(SW'(x3) + SW'(i_cfg.off_x));
                r_yt <= clampw(SW'(y3) + SW'(i_cfg.off_y));
                r_zt <= clampw(SW'(r_zd[1]) + SW'(i_cfg.off_z));
            end
        end
    end

    // z minus one for projection
    logic                r_vp, r_lp, r_dp;
    logic signed [W-1:0] r_xp, r_yp, r_zp;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) r_vp <= 1'b0;
        else if (en)  r_vp <= r_vt;
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_lp <= r_lt;
            r_dp <= (r_opt == ertp_pkg::OP_PROJECT);
            r_xp <= r_xt;
            r_yp <= r_yt;
            r_zp <= (r_opt == ertp_pkg::OP_PROJECT) ? clampw(SW'(r_zt) - ONE_Q16) : r_zt;
        end
    end

    // divider: index 0 is setup, each later index one quotient bit
    logic                r_dv [0:NQ];
    logic                r_dl [0:NQ];
    logic                r_dd [0:NQ];
    logic                r_df [0:NQ];
    logic                r_ngx [0:NQ];
    logic                r_ngy [0:NQ];
    logic signed [W-1:0] r_px [0:NQ];
    logic signed [W-1:0] r_py [0:NQ];
    logic signed [W-1:0] r_pz [0:NQ];
    logic        [W-1:0] r_az [0:NQ];
    logic       [NQ-1:0] r_nx [0:NQ];
    logic       [NQ-1:0] r_ny [0:NQ];
    logic        [W-1:0] r_rx [0:NQ];
    logic        [W-1:0] r_ry [0:NQ];
    logic       [NQ-1:0] r_qx [0:NQ];
    logic       [NQ-1:0] r_qy [0:NQ];
    logic          [W:0] c_tx [1:NQ];
    logic          [W:0] c_ty [1:NQ];
    logic                c_bx [1:NQ];
    logic                c_by [1:NQ];
    logic          [W:0] c_dx [1:NQ];
    logic          [W:0] c_dy [1:NQ];
    logic        [W-1:0] ax, ay, az;

    always_comb begin
        ax = r_xp[W-1] ? W'(-r_xp) : W'(r_xp);
        ay = r_yp[W-1] ? W'(-r_yp) : W'(r_yp);
        az = r_zp[W-1] ? W'(-r_zp) : W'(r_zp);
        for (int k = 1; k <= NQ; k++) begin
            c_tx[k] = {r_rx[k-1], r_nx[k-1][NQ-1]};
            c_ty[k] = {r_ry[k-1], r_ny[k-1][NQ-1]};
            c_bx[k] = (c_tx[k] >= {1'b0, r_az[k-1]});
            c_by[k] = (c_ty[k] >= {1'b0, r_az[k-1]});
            c_dx[k] = c_bx[k] ? c_tx[k] - {1'b0, r_az[k-1]} : c_tx[k];
            c_dy[k] = c_by[k] ? c_ty[k] - {1'b0, r_az[k-1]} : c_ty[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            for (int k = 0; k <= NQ; k++) r_dv[k] <= 1'b0;
        end else if (en) begin
            r_dv[0] <= r_vp;
            for (int k = 1; k <= NQ; k++) r_dv[k] <= r_dv[k-1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (en) begin
            r_dl[0]  <= r_lp;
            r_dd[0]  <= r_dp;
            r_df[0]  <= r_dp && (r_zp == '0);
            r_ngx[0] <= r_xp[W-1] != r_zp[W-1];
            r_ngy[0] <= r_yp[W-1] != r_zp[W-1];
            r_px[0]  <= r_xp;
            r_py[0]  <= r_yp;
            r_pz[0]  <= r_zp;
            r_az[0]  <= az;
            r_nx[0]  <= {ax, 16'b0};
            r_ny[0]  <= {ay, 16'b0};
            r_rx[0]  <= '0;
            r_ry[0]  <= '0;
            r_qx[0]  <= '0;
            r_qy[0]  <= '0;
            for (int k = 1; k <= NQ; k++) begin
                r_dl[k]  <= r_dl[k-1];
                r_dd[k]  <= r_dd[k-1];
                r_df[k]  <= r_df[k-1];
                r_ngx[k] <= r_ngx[k-1];
                r_ngy[k] <= r_ngy[k-1];
                r_px[k]  <= r_px[k-1];
                r_py[k]  <= r_py[k-1];
                r_pz[k]  <= r_pz[k-1];
                r_az[k]  <= r_az[k-1];
                r_nx[k]  <= {r_nx[k-1][NQ-2:0], 1'b0};
                r_ny[k]  <= {r_ny[k-1][NQ-2:0], 1'b0};
                r_rx[k]  <= c_dx[k][W-1:0];
                r_ry[k]  <= c_dy[k][W-1:0];
                r_qx[k]  <= {r_qx[k-1][NQ-2:0], c_bx[k]};
                r_qy[k]  <= {r_qy[k-1][NQ-2:0], c_by[k]};
            end
        end
    end

    // result select and saturation
    logic signed [W-1:0] xo, yo;

    always_comb begin
        if (!r_dd[NQ]) begin
            xo = r_px[NQ];
            yo = r_py[NQ];
        end else if (r_df[NQ]) begin
            xo = fsat(r_px[NQ]);
            yo = fsat(r_py[NQ]);
        end else begin
            xo = qsat(r_qx[NQ], r_ngx[NQ]);
            yo = qsat(r_qy[NQ], r_ngy[NQ]);
        end
        o_res.x_out        = 32'(xo);
        o_res.y_out        = 32'(yo);
        o_res.z_out        = 32'(r_pz[NQ]);
        o_res.divide_fault = r_df[NQ];
        o_res.last_out     = r_dl[NQ];
    end

    assign o_push = en && r_dv[NQ];

    a_push_room: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_push |-> !i_full) else $error("push into full output queue");
    a_pop_data: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_pop |-> !i_empty) else $error("pop from empty input queue");
    a_fault_z: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_push && o_res.divide_fault) |-> (r_pz[NQ] == '0 && r_dd[NQ]))
        else $error("divide fault without zero divisor");
    a_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_full && r_dv[NQ]) |=> r_dv[NQ]) else $error("result lost during stall");

endmodule

// ===== hdl/euler_rotate_translate_project.sv =====
// Top level of the Euler rotate/translate/project vertex block.
// Depends on ertp_pkg, ertp_front, ertp_back and ertp_fifo.
//
// Usage:
//   Vertex words enter on i_vtx with push/full and leave on o_res with
//   empty/pop; both sides behave as queues. The user must write registers
//   through the APB port (word i at byte address 4*i) only while no vertex
//   is in flight; the block does not enforce this. One vertex is taken
//   every cycle while the output is being drained. Each vertex passes the
//   six rotation stages, translation, then the one-bit-per-stage divider.
//   When the receiver stops popping, the output queue fills, the whole back
//   pipeline holds, then the front queue fills and full rises; no word is
//   dropped. Reset (synchronous, active low) empties both queues and the
//   pipeline and returns the registers to cos 1.0, sin 0, zero offsets,
//   projection off.
`timescale 1ns / 1ps

module euler_rotate_translate_project #(
    parameter int COORD_WIDTH = 32
) (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        psel,
    input  logic                        penable,
    input  logic                        pwrite,
    input  logic [ertp_pkg::ADDR_W-1:0] paddr,
    input  logic [31:0]                 pwdata,
    output logic [31:0]                 prdata,
    output logic                        pready,
    input  logic                        push,
    output logic                        full,
    input  ertp_pkg::t_vtx_in           i_vtx,
    output logic                        empty,
    input  logic                        pop,
    output ertp_pkg::t_vtx_out          o_res
);

    ertp_pkg::t_cfg     r_cfg;
    ertp_pkg::t_item    item;
    ertp_pkg::t_vtx_out res;
    logic               mid_empty, mid_pop, out_full, out_push;
    logic [2:0]         idx;

    assign pready = 1'b1;
    assign idx    = paddr[4:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.sc_x    <= ertp_pkg::SC_RESET;
            r_cfg.sc_y    <= ertp_pkg::SC_RESET;
            r_cfg.sc_z    <= ertp_pkg::SC_RESET;
            r_cfg.off_x   <= '0;
            r_cfg.off_y   <= '0;
            r_cfg.off_z   <= '0;
            r_cfg.project <= 1'b0;
        end else if (psel && penable && pwrite && pready) begin
            case (idx)
                ertp_pkg::REG_SC_X:  r_cfg.sc_x    <= pwdata;
                ertp_pkg::REG_SC_Y:  r_cfg.sc_y    <= pwdata;
                ertp_pkg::REG_SC_Z:  r_cfg.sc_z    <= pwdata;
                ertp_pkg::REG_OFF_X: r_cfg.off_x   <= signed'(pwdata);
                ertp_pkg::REG_OFF_Y: r_cfg.off_y   <= signed'(pwdata);
                ertp_pkg::REG_OFF_Z: r_cfg.off_z   <= signed'(pwdata);
                ertp_pkg::REG_PROJ:  r_cfg.project <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (idx)
            ertp_pkg::REG_SC_X:  prdata = r_cfg.sc_x;
            ertp_pkg::REG_SC_Y:  prdata = r_cfg.sc_y;
            ertp_pkg::REG_SC_Z:  prdata = r_cfg.sc_z;
            ertp_pkg::REG_OFF_X: prdata = r_cfg.off_x;
            ertp_pkg::REG_OFF_Y: prdata = r_cfg.off_y;
            ertp_pkg::REG_OFF_Z: prdata = r_cfg.off_z;
            ertp_pkg::REG_PROJ:  prdata = {31'b0, r_cfg.project};
            default:             prdata = '0;
        endcase
    end

    ertp_front u_front (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_project(r_cfg.project),
        .i_push   (push),
        .o_full   (full),
        .i_vtx    (i_vtx),
        .i_pop    (mid_pop),
        .o_empty  (mid_empty),
        .o_item   (item)
    );

    ertp_back #(.W(COORD_WIDTH)) u_back (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_cfg  (r_cfg),
        .i_empty(mid_empty),
        .o_pop  (mid_pop),
        .i_item (item),
        .i_full (out_full),
        .o_push (out_push),
        .o_res  (res)
    );

    ertp_fifo #(.WIDTH($bits(ertp_pkg::t_vtx_out))) u_outq (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_push (out_push),
        .i_pop  (pop),
        .i_data (res),
        .o_full (out_full),
        .o_empty(empty),
        .o_data (o_res)
    );

endmodule
